### hw/rtl/tes_pkg.sv
// Shared types and codes for the triangle edge set builder.
// Request and result payloads, status codes, controller/datapath links.
// No dependencies.
package tes_pkg;

  localparam int VTX_W    = 16;
  localparam int SLOT_W   = 8;
  localparam int HELD_W   = 9;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_DEGEN   = 3'd3,
    ST_CLEARED = 3'd4
  } tes_status_t;

  typedef struct packed {
    logic             action;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
    logic [VTX_W-1:0] vertex_c;
  } tes_req_t;

  typedef struct packed {
    tes_status_t       status;
    logic [VTX_W-1:0]  edge_low;
    logic [VTX_W-1:0]  edge_high;
    logic [SLOT_W-1:0] slot;
    logic [HELD_W-1:0] edges_held;
    logic              last;
  } tes_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        scan_step;
    logic        next_edge;
    logic        emit;
    tes_status_t emit_code;
  } tes_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic degen;
    logic hit;
    logic exhausted;
    logic full;
    logic last_edge;
  } tes_stat_t;

endpackage

### hw/rtl/tes_ctrl.sv
// Controller state machine of the triangle edge set builder.
// Depends on tes_pkg for the command and status structs.
module tes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              action,
  input  tes_pkg::tes_stat_t stat,
  output tes_pkg::tes_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_code = tes_pkg::ST_NEW;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (action) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = tes_pkg::ST_CLEARED;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.degen) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = tes_pkg::ST_DEGEN;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.exhausted) begin
          cmd.emit = 1'b1;
          if (stat.hit) begin
            cmd.emit_code = tes_pkg::ST_PRESENT;
          end else if (stat.full) begin
            cmd.emit_code = tes_pkg::ST_FULL;
          end else begin
            cmd.emit_code = tes_pkg::ST_NEW;
          end
          // advance to the next edge, or finish after the third
          if (stat.last_edge) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_edge = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hw/rtl/tes_datapath.sv
// Datapath of the triangle edge set builder: sort, edge memory, scan, result.
// Depends on tes_pkg; driven by tes_ctrl commands.
module tes_datapath #(
  parameter int EDGE_CAPACITY = 256,
  parameter int VERTEX_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tes_pkg::tes_req_t  in_req,
  input  tes_pkg::tes_cmd_t  cmd,
  output tes_pkg::tes_stat_t stat,
  output logic               out_valid,
  output tes_pkg::tes_res_t  out_res
);

  localparam int VB = VERTEX_BITS;
  localparam int IW = $clog2(EDGE_CAPACITY);
  localparam int CW = $clog2(EDGE_CAPACITY + 1);
  localparam logic [1:0] EDGE_LM = 2'd0;
  localparam logic [1:0] EDGE_MH = 2'd1;
  localparam logic [1:0] EDGE_LH = 2'd2;

  logic [2*VB-1:0] mem [EDGE_CAPACITY];
  logic [2*VB-1:0] rdata_r;

  logic [VB-1:0] lo_r, mid_r, hi_r;
  logic [1:0]    edge_sel_r;
  logic [CW-1:0] total_r, rd_ptr_r, cmp_ptr_r;
  logic          rv_r;
  logic          vld_r;
  tes_pkg::tes_res_t res_r;
  tes_pkg::tes_res_t res_nxt;

  logic [VB-1:0] va, vb, vc, s0, s1, s2, t0, t1;
  logic [VB-1:0] cur_lo, cur_hi;
  logic          rd_en, wr_en;

  // Three compare-exchange steps sort the vertices ascending.
  always_comb begin
    va = VB'(in_req.vertex_a);
    vb = VB'(in_req.vertex_b);
    vc = VB'(in_req.vertex_c);
    s0 = (va > vb) ? vb : va;
    t0 = (va > vb) ? va : vb;
    s1 = (t0 > vc) ? vc : t0;
    s2 = (t0 > vc) ? t0 : vc;
    t1 = (s0 > s1) ? s0 : s1;
    s0 = (s0 > s1) ? s1 : s0;
    s1 = t1;
  end

  always_comb begin
    case (edge_sel_r)
      EDGE_LM: begin cur_lo = lo_r;  cur_hi = mid_r; end
      EDGE_MH: begin cur_lo = mid_r; cur_hi = hi_r;  end
      EDGE_LH: begin cur_lo = lo_r;  cur_hi = hi_r;  end
      default: begin cur_lo = lo_r;  cur_hi = hi_r;  end
    endcase
  end

  assign rd_en = cmd.scan_step && (rd_ptr_r < total_r);
  assign wr_en = cmd.emit && (cmd.emit_code == tes_pkg::ST_NEW);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[total_r[IW-1:0]] <= {cur_lo, cur_hi};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_ptr_r[IW-1:0]];
    end
  end

  assign stat.degen     = (lo_r == mid_r) || (mid_r == hi_r);
  assign stat.hit       = rv_r && (rdata_r == {cur_lo, cur_hi});
  assign stat.exhausted = !rv_r && (rd_ptr_r >= total_r);
  assign stat.full      = (total_r == CW'(EDGE_CAPACITY));
  assign stat.last_edge = (edge_sel_r == EDGE_LH);

  // Sorted vertices and the compare pointer are payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r  <= s0;
      mid_r <= s1;
      hi_r  <= s2;
    end
    if (rd_en) begin
      cmp_ptr_r <= rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_sel_r <= EDGE_LM;
      rd_ptr_r   <= '0;
      rv_r       <= 1'b0;
      total_r    <= '0;
    end else begin
      if (cmd.load || cmd.next_edge) begin
        rd_ptr_r <= '0;
        rv_r     <= 1'b0;
      end else if (cmd.scan_step) begin
        rv_r <= rd_en;
        if (rd_en) begin
          rd_ptr_r <= rd_ptr_r + CW'(1);
        end
      end
      if (cmd.load) begin
        edge_sel_r <= EDGE_LM;
      end else if (cmd.next_edge) begin
        edge_sel_r <= edge_sel_r + 2'd1;
      end
      if (cmd.emit && (cmd.emit_code == tes_pkg::ST_CLEARED)) begin
        total_r <= '0;
      end else if (wr_en) begin
        total_r <= total_r + CW'(1);
      end
    end
  end

  // Result register: one strobe per emit command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cmd.emit;
    end
  end

  always_comb begin
    res_nxt.status     = cmd.emit_code;
    res_nxt.edge_low   = tes_pkg::VTX_W'(cur_lo);
    res_nxt.edge_high  = tes_pkg::VTX_W'(cur_hi);
    res_nxt.slot       = '0;
    res_nxt.edges_held = tes_pkg::HELD_W'(total_r);
    res_nxt.last       = (edge_sel_r == EDGE_LH);
    case (cmd.emit_code)
      tes_pkg::ST_NEW: begin
        res_nxt.slot       = tes_pkg::SLOT_W'(total_r);
        res_nxt.edges_held = tes_pkg::HELD_W'(total_r + CW'(1));
      end
      tes_pkg::ST_PRESENT: begin
        res_nxt.slot = tes_pkg::SLOT_W'(cmp_ptr_r);
      end
      tes_pkg::ST_FULL: begin
        res_nxt.slot = '0;
      end
      tes_pkg::ST_DEGEN: begin
        res_nxt.edge_low  = '0;
        res_nxt.edge_high = '0;
        res_nxt.last      = 1'b1;
      end
      tes_pkg::ST_CLEARED: begin
        res_nxt.edge_low   = '0;
        res_nxt.edge_high  = '0;
        res_nxt.edges_held = '0;
        res_nxt.last       = 1'b1;
      end
      default: begin
        res_nxt.slot = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

### hw/rtl/triangle_edge_set_builder.sv
// Top level of the triangle edge set builder: unique mesh edge extraction.
// Depends on tes_pkg, tes_ctrl and tes_datapath.
//
//   channel   ports                     handshake
//   request   start, busy, in_req       taken at a clock edge with start high, busy low
//   result    out_valid, out_res        one-cycle strobe, always taken
//
// A clear does not raise busy; its result strobes on the next cycle. An
// insert holds busy for the repeat check (a reject ends there), then per
// edge scans the held edges, one memory read per cycle, until a hit or the
// end of the list. Each result strobes the cycle after its edge is decided.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// unfilled memory entries are never read. The receiver cannot stall.
module triangle_edge_set_builder #(
  parameter int EDGE_CAPACITY = 256,
  parameter int VERTEX_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tes_pkg::tes_req_t in_req,
  output logic              out_valid,
  output tes_pkg::tes_res_t out_res
);

  tes_pkg::tes_cmd_t  cmd;
  tes_pkg::tes_stat_t stat;

  // Sequence each request: a clear, or load and sort, check for repeats, scan per edge.
  tes_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_req.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the sorted triangle, the edge memory, the count and the result register.
  tes_datapath #(
    .EDGE_CAPACITY (EDGE_CAPACITY),
    .VERTEX_BITS   (VERTEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

### hw/rtl/tes_checker.sv
// Port-level checks for the triangle edge set builder, bound to the top level.
// Depends on tes_pkg and triangle_edge_set_builder.
module tes_checker #(
  parameter int EDGE_CAPACITY = 256
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input tes_pkg::tes_req_t in_req,
  input logic              out_valid,
  input tes_pkg::tes_res_t out_res
);

  // More results of the same request follow: the block must still be busy.
  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |-> busy)
    else $error("non-final result while idle");

  // A clear request answers on the next cycle with one final cleared result.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.action) |=>
      (out_valid && out_res.last && (out_res.status == tes_pkg::ST_CLEARED)
       && (out_res.edges_held == '0)))
    else $error("clear request not answered");

  // The count never exceeds the capacity.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.edges_held <= tes_pkg::HELD_W'(EDGE_CAPACITY)))
    else $error("edge count above capacity");

  // A stored edge is always strictly ordered.
  a_new_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == tes_pkg::ST_NEW)) |->
      (out_res.edge_low < out_res.edge_high))
    else $error("new edge not ordered");

endmodule

bind triangle_edge_set_builder tes_checker #(.EDGE_CAPACITY(EDGE_CAPACITY)) u_tes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

### test/tb_top.sv
// Self-checking bench for triangle_edge_set_builder: directed and random triangle
// requests checked against a predictor of the unique edge list.
// Depends on tes_pkg and the triangle_edge_set_builder RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int EDGE_CAP   = 256;
  localparam int CLK_HALF   = 2;
  localparam int RESET_CYC  = 4;
  // Longest busy stretch of one insert: three scans of a full list.
  localparam int INSERT_MAX = 3 * (EDGE_CAP + 2) + 1;

  // One queued request: payload, chance in percent of idling per cycle
  // before it goes out, and whether to drain every result first.
  typedef struct {
    tes_pkg::tes_req_t req;
    int unsigned       gap_pct;
    bit                drain;
  } queued_req_t;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  tes_pkg::tes_req_t in_req = '0;
  logic              out_valid;
  tes_pkg::tes_res_t out_res;

  queued_req_t       req_backlog[$];
  tes_pkg::tes_res_t edge_results_due[$];

  // Predicted edge list and its fill count.
  logic [tes_pkg::VTX_W-1:0] list_lo[EDGE_CAP];
  logic [tes_pkg::VTX_W-1:0] list_hi[EDGE_CAP];
  int unsigned               list_count = 0;

  int unsigned reqs_taken   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned status_tally[5] = '{default: 0};

  triangle_edge_set_builder #(
    .EDGE_CAPACITY(EDGE_CAP),
    .VERTEX_BITS  (tes_pkg::VTX_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #CLK_HALF clk = ~clk;

  // ------------------------------------------------------------------
  // Edge list predictor
  // ------------------------------------------------------------------

  // Append one predicted result to the outstanding list.
  function automatic void note_result(tes_pkg::tes_res_t r);
    edge_results_due.insert(edge_results_due.size(), r);
  endfunction

  // Look one edge up in the list; append it if absent and there is room.
  function automatic tes_pkg::tes_res_t file_edge(logic [tes_pkg::VTX_W-1:0] lo,
                                                  logic [tes_pkg::VTX_W-1:0] hi,
                                                  logic last_flag);
    tes_pkg::tes_res_t res;
    res = '0;
    res.edge_low  = lo;
    res.edge_high = hi;
    res.last      = last_flag;
    for (int i = 0; i < list_count; i++) begin
      if (list_lo[i] == lo && list_hi[i] == hi) begin
        res.status     = tes_pkg::ST_PRESENT;
        res.slot       = tes_pkg::SLOT_W'(i);
        res.edges_held = tes_pkg::HELD_W'(list_count);
        return res;
      end
    end
    if (list_count >= EDGE_CAP) begin
      // List is full: drop the edge, report slot zero.
      res.status     = tes_pkg::ST_FULL;
      res.edges_held = tes_pkg::HELD_W'(list_count);
      return res;
    end
    list_lo[list_count] = lo;
    list_hi[list_count] = hi;
    list_count++;
    res.status     = tes_pkg::ST_NEW;
    res.slot       = tes_pkg::SLOT_W'(list_count - 1);
    res.edges_held = tes_pkg::HELD_W'(list_count);
    return res;
  endfunction

  // Work out every result that one accepted request will cause, in order.
  function automatic void predict_triangle(tes_pkg::tes_req_t r);
    logic [tes_pkg::VTX_W-1:0] lo, mid, hi, t;
    tes_pkg::tes_res_t         res;
    res = '0;
    if (r.action) begin
      list_count = 0;
      res.status = tes_pkg::ST_CLEARED;
      res.last   = 1'b1;
      note_result(res);
      return;
    end
    lo  = r.vertex_a;
    mid = r.vertex_b;
    hi  = r.vertex_c;
    if (lo > mid) begin t = lo; lo = mid; mid = t; end
    if (mid > hi) begin t = mid; mid = hi; hi = t; end
    if (lo > mid) begin t = lo; lo = mid; mid = t; end
    if (lo == mid || mid == hi) begin
      // Repeated vertex: one reject result, list untouched.
      res.status     = tes_pkg::ST_DEGEN;
      res.edges_held = tes_pkg::HELD_W'(list_count);
      res.last       = 1'b1;
      note_result(res);
      return;
    end
    note_result(file_edge(lo, mid, 1'b0));
    note_result(file_edge(mid, hi, 1'b0));
    note_result(file_edge(lo, hi, 1'b1));
  endfunction

  // ------------------------------------------------------------------
  // Stimulus builders
  // ------------------------------------------------------------------

  task automatic push_req(logic action, int unsigned va, int unsigned vb, int unsigned vc,
                          int unsigned gap_pct, bit drain);
    queued_req_t q;
    q.req.action   = action;
    q.req.vertex_a = tes_pkg::VTX_W'(va);
    q.req.vertex_b = tes_pkg::VTX_W'(vb);
    q.req.vertex_c = tes_pkg::VTX_W'(vc);
    q.gap_pct      = gap_pct;
    q.drain        = drain;
    req_backlog.insert(req_backlog.size(), q);
  endtask

  // Mostly triangles over a small vertex pool so edges recur; the rest is
  // wide random triangles, repeated-vertex rejects and clears.
  task automatic build_mesh_phase(int unsigned count, int unsigned gap_pct);
    int unsigned base, pick, v, w;
    base = $urandom_range(0, 65535 - 12);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 0 || pick < 70) begin
        push_req(1'b0, base + $urandom_range(0, 11), base + $urandom_range(0, 11),
                 base + $urandom_range(0, 11), gap_pct, i == 0);
      end else if (pick < 84) begin
        push_req(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), gap_pct, 1'b0);
      end else if (pick < 95) begin
        v = $urandom_range(0, 65535);
        w = $urandom_range(0, 65535);
        case ($urandom_range(0, 2))
          0: push_req(1'b0, v, v, w, gap_pct, 1'b0);
          1: push_req(1'b0, w, v, v, gap_pct, 1'b0);
          default: push_req(1'b0, v, w, v, gap_pct, 1'b0);
        endcase
      end else begin
        push_req(1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), gap_pct, 1'b0);
      end
    end
  endtask

  // Fill the list past capacity with disjoint triangles, then probe it while full.
  task automatic build_fill_phase(int unsigned gap_pct);
    int unsigned base, k;
    base = $urandom_range(0, 65535 - 320);
    push_req(1'b1, 0, 0, 0, gap_pct, 1'b1);
    // 86 triangles of three fresh edges overrun the 256 slots mid-triangle.
    for (int i = 0; i < 86; i++) begin
      case ($urandom_range(0, 2))
        0: push_req(1'b0, base + 3*i, base + 3*i + 1, base + 3*i + 2, gap_pct, 1'b0);
        1: push_req(1'b0, base + 3*i + 2, base + 3*i, base + 3*i + 1, gap_pct, 1'b0);
        default: push_req(1'b0, base + 3*i + 1, base + 3*i + 2, base + 3*i, gap_pct, 1'b0);
      endcase
    end
    for (int i = 0; i < 4; i++) begin
      k = $urandom_range(0, 84);
      push_req(1'b0, base + 3*k + 2, base + 3*k + 1, base + 3*k, gap_pct, 1'b0);
    end
    for (int i = 0; i < 3; i++)
      push_req(1'b0, base + 3*(90 + i), base + 3*(90 + i) + 1, base + 3*(90 + i) + 2,
               gap_pct, 1'b0);
    // One edge held, two dropped.
    push_req(1'b0, base, base + 1, base + 310, gap_pct, 1'b0);
    push_req(1'b0, base + 7, base + 7, base + 9, gap_pct, 1'b0);
    push_req(1'b1, base, base, base, gap_pct, 1'b0);
    push_req(1'b0, base + 3, base + 1, base + 2, gap_pct, 1'b0);
  endtask

  // ------------------------------------------------------------------
  // Request driver
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    bit          free;
    bit          go;
    queued_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      free = 1'b1;
      go   = 1'b0;
      if (start && !busy) begin
        // Request taken at this edge: advance the predictor.
        predict_triangle(in_req);
        reqs_taken++;
      end else if (start) begin
        // Block still busy: hold the request.
        free = 1'b0;
      end
      if (free) begin
        if (req_backlog.size() != 0) begin
          nxt = req_backlog[0];
          if (!(nxt.drain && edge_results_due.size() != 0))
            go = ($urandom_range(0, 99) >= nxt.gap_pct);
        end
        if (go) begin
          start  <= 1'b1;
          in_req <= nxt.req;
          void'(req_backlog.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result monitor
  // ------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tes_pkg::tes_res_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (edge_results_due.size() == 0) begin
        $error("result with nothing outstanding: status %0d edge (%0d,%0d)",
               out_res.status, out_res.edge_low, out_res.edge_high);
        fail_count++;
      end else begin
        want = edge_results_due.pop_front();
        status_tally[want.status]++;
        check_field("status", want.status, out_res.status);
        check_field("edge_low", want.edge_low, out_res.edge_low);
        check_field("edge_high", want.edge_high, out_res.edge_high);
        check_field("slot", want.slot, out_res.slot);
        check_field("edges_held", want.edges_held, out_res.edges_held);
        check_field("last", want.last, out_res.last);
      end
    end
  end

  // ------------------------------------------------------------------
  // Sequence: reset, directed requests, three random phases, wind-down
  // ------------------------------------------------------------------
  initial begin
    // Directed: clear on an empty list, every kind of repeated vertex,
    // permuted repeats, extreme and alternating-bit indices, a clear
    // carrying junk vertices, and a reject while edges are held.
    push_req(1'b1, 0, 0, 0, 0, 1'b0);
    push_req(1'b0, 5, 3, 4, 0, 1'b0);
    push_req(1'b0, 4, 5, 3, 0, 1'b0);
    push_req(1'b0, 3, 3, 7, 0, 1'b0);
    push_req(1'b0, 9, 8, 8, 0, 1'b0);
    push_req(1'b0, 6, 2, 6, 0, 1'b0);
    push_req(1'b0, 0, 0, 0, 0, 1'b0);
    push_req(1'b0, 65535, 65535, 65535, 0, 1'b0);
    push_req(1'b0, 65535, 0, 32768, 0, 1'b0);
    push_req(1'b0, 65534, 65535, 0, 0, 1'b0);
    push_req(1'b0, 16'hAAAA, 16'h5555, 16'hFFFF, 0, 1'b0);
    push_req(1'b0, 16'h5555, 16'hAAAA, 16'h0001, 0, 1'b0);
    push_req(1'b0, 3, 5, 6, 0, 1'b0);
    push_req(1'b0, 1, 2, 4, 0, 1'b0);
    push_req(1'b0, 4, 2, 1, 0, 1'b0);
    push_req(1'b1, 0, 0, 0, 0, 1'b0);
    push_req(1'b0, 5, 4, 3, 0, 1'b0);
    push_req(1'b1, 16'hFFFF, 16'h1234, 16'h8000, 0, 1'b0);
    push_req(1'b0, 10, 11, 12, 0, 1'b0);
    push_req(1'b0, 12, 12, 12, 0, 1'b0);
    push_req(1'b0, 12, 10, 11, 0, 1'b0);

    build_mesh_phase(85, 35);
    build_mesh_phase(85, 69);
    build_fill_phase(0);

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver's updates have settled.
    while (req_backlog.size() != 0 || start || edge_results_due.size() != 0)
      @(negedge clk);
    // Watch a while longer for stray results.
    repeat (INSERT_MAX + 16) @(negedge clk);

    $display("Covered %0d requests and %0d results: %0d new, %0d present, %0d dropped,",
             reqs_taken, results_seen, status_tally[tes_pkg::ST_NEW],
             status_tally[tes_pkg::ST_PRESENT], status_tally[tes_pkg::ST_FULL]);
    $display("%0d repeated-vertex rejects, %0d clears, list filled to capacity.",
             status_tally[tes_pkg::ST_DEGEN], status_tally[tes_pkg::ST_CLEARED]);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d requests queued, %0d results outstanding",
             req_backlog.size(), edge_results_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
